[design/assert_macros.svh]
// assertion macros shared by the activation unit rtl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// antecedent implies consequent in the same cycle, checked out of reset
`define ASSERT_IMPLIES(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error(msg);

// condition must never be seen out of reset
`define ASSERT_NEVER(label, clk, rstn, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) !(cond)) \
        else $error(msg);

`else

`define ASSERT_IMPLIES(label, clk, rstn, ante, cons, msg)
`define ASSERT_NEVER(label, clk, rstn, cond, msg)

`endif

`endif

[design/nau_pkg.sv]
// shared types, constants and sigmoid table generator for the activation unit
`default_nettype none

package nau_pkg;

    localparam int DATA_WIDTH      = 16;
    localparam int FRAC_BITS       = 8;
    localparam int SIG_TABLE_DEPTH = 256;
    localparam int ADDR_WIDTH      = 4;

    typedef enum logic [1:0] {
        MODE_STEP    = 2'd0,
        MODE_LINEAR  = 2'd1,
        MODE_SIGMOID = 2'd2,
        MODE_DERIV   = 2'd3
    } mode_t;

    localparam mode_t MODE_RESET = MODE_SIGMOID;

    // register indexes, taken from paddr word address bits
    localparam logic [1:0] REG_MODE   = 2'd0;
    localparam logic [1:0] REG_SLOPE  = 2'd1;
    localparam logic [1:0] REG_OFFSET = 2'd2;

    localparam longint unsigned Q30 = 64'd1 << 30;

    typedef struct packed {
        logic big;   // magnitude at or above 8.0
        logic neg;   // sample is negative
    } sig_ctl_t;

    // restoring long division, elaboration only
    function automatic longint unsigned udiv64(input longint unsigned num,
                                               input longint unsigned den);
        longint unsigned q;
        longint unsigned r;
        q = 64'd0;
        r = 64'd0;
        for (int b = 63; b >= 0; b--) begin
            r = {r[62:0], num[b]};
            q = q << 1;
            if (r >= den) begin
                r    = r - den;
                q[0] = 1'b1;
            end
        end
        return q;
    endfunction

    // round(2^frac / (1 + exp(-a))), a = (2i+1)*4/depth, exact integer form
    function automatic longint unsigned sig_rom_entry(input longint unsigned i,
                                                      input longint unsigned depth,
                                                      input longint unsigned frac);
        longint unsigned y;
        longint unsigned term;
        longint          sum;
        longint unsigned e;
        longint unsigned d;
        y    = udiv64(((64'd2 * i + 64'd1) << 30) + 64'd2 * depth, 64'd4 * depth);
        term = Q30;
        sum  = longint'(Q30);
        // taylor series of exp(-a/16) in q30
        for (int k = 1; k <= 16; k++) begin
            term = udiv64((term * y) >> 30, 64'(k));
            if (k % 2 == 1) begin
                sum = sum - longint'(term);
            end else begin
                sum = sum + longint'(term);
            end
        end
        e = unsigned'(sum);
        // square four times to reach exp(-a)
        for (int k = 0; k < 4; k++) begin
            e = (e * e + (Q30 >> 1)) >> 30;
        end
        d = Q30 + e;
        return udiv64((64'd1 << (frac + 64'd31)) + d, 64'd2 * d);
    endfunction

endpackage

`default_nettype wire

[design/neural_activation_unit.sv]
// neural activation unit: step, linear, sigmoid and sigmoid derivative in fixed point
// throughput: one request per cycle unless the pipe is full and m_tready is low;
// the three register stages (stage 1, stage 2, output) each hold one item and
// advance on their own, so empty stages fill while the output request waits
// reset (aresetn low, synchronous): pipeline emptied, mode = sigmoid, slope = 1.0,
// offset = 0; no table fill is needed, the sigmoid table is constant logic
`default_nettype none
`include "assert_macros.svh"

module neural_activation_unit #(
    parameter int DATA_WIDTH      = nau_pkg::DATA_WIDTH,
    parameter int FRAC_BITS       = nau_pkg::FRAC_BITS,
    parameter int SIG_TABLE_DEPTH = nau_pkg::SIG_TABLE_DEPTH
) (
    input  wire logic                                aclk,
    input  wire logic                                aresetn,

    // input stream
    input  wire logic                                s_tvalid,
    output logic                                     s_tready,
    input  wire logic [((DATA_WIDTH+7)/8)*8-1:0]     s_tdata,   // sample

    // result stream
    output logic                                     m_tvalid,
    input  wire logic                                m_tready,
    output logic [((DATA_WIDTH+7)/8)*8-1:0]          m_tdata,   // activation
    output logic [0:0]                               m_tuser,   // clipped

    // register port
    input  wire logic                                psel,
    input  wire logic                                penable,
    input  wire logic                                pwrite,
    input  wire logic [nau_pkg::ADDR_WIDTH-1:0]      paddr,
    input  wire logic [31:0]                         pwdata,
    output logic [31:0]                              prdata,
    output logic                                     pready
);

    // widths
    localparam int W  = DATA_WIDTH;
    localparam int F  = FRAC_BITS;
    localparam int D  = SIG_TABLE_DEPTH;
    localparam int IW = $clog2(D);
    localparam int TW = ((W + 7) / 8) * 8;
    localparam int SW = F + 1;                       // sigmoid value 0 .. 1.0
    localparam int PW = 2 * W;                       // linear product
    localparam int LW = 2 * W + 1;                   // shifted product plus offset
    localparam int MW = (W + 1 > F + 4) ? W + 1 : F + 4;
    localparam int XW = (W > F + 2) ? W : F + 2;     // non-negative results before clamp
    localparam int QW = MW + IW + 1;                 // table index product

    localparam logic [XW-1:0]        ONE_X    = XW'(1) << F;
    localparam logic [SW-1:0]        ONE_S    = SW'(1) << F;
    localparam logic [XW-1:0]        DMAX_X   = XW'({(W-1){1'b1}});
    localparam logic signed [LW-1:0] LMAX     = LW'({(W-1){1'b1}});
    localparam logic signed [LW-1:0] LMIN     = ~LMAX;
    localparam logic [MW-1:0]        EIGHT_M  = MW'(8) << F;
    localparam logic [QW-1:0]        DEPTH_Q  = QW'(D);
    localparam logic [W-1:0]         SLOPE_RST = W'(ONE_X);

    // clamp a non-negative value to the signed data range
    function automatic logic [W-1:0] sat_u(input logic [XW-1:0] v);
        return (v > DMAX_X) ? W'(DMAX_X) : W'(v);
    endfunction

    // ------------------------------------------------------------------
    // configuration registers
    // ------------------------------------------------------------------
    nau_pkg::mode_t      mode_reg;
    logic signed [W-1:0] slope_reg;
    logic signed [W-1:0] offset_reg;
    logic                cfg_wr;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg   <= nau_pkg::MODE_RESET;
            slope_reg  <= SLOPE_RST;
            offset_reg <= '0;
        end else if (cfg_wr) begin
            // writes to an unknown index fall through untouched
            if (paddr[3:2] == nau_pkg::REG_MODE) begin
                mode_reg <= nau_pkg::mode_t'(pwdata[1:0]);
            end
            if (paddr[3:2] == nau_pkg::REG_SLOPE) begin
                slope_reg <= pwdata[W-1:0];
            end
            if (paddr[3:2] == nau_pkg::REG_OFFSET) begin
                offset_reg <= pwdata[W-1:0];
            end
        end
    end

    always_comb begin
        unique case (paddr[3:2])
            nau_pkg::REG_MODE:   prdata = 32'(mode_reg);
            nau_pkg::REG_SLOPE:  prdata = 32'(slope_reg);
            nau_pkg::REG_OFFSET: prdata = 32'(offset_reg);
            default:             prdata = '0;
        endcase
    end

    // ------------------------------------------------------------------
    // pipeline flow control: each stage moves when it is empty or the
    // stage after it moves, so bubbles squeeze out under back-pressure
    // ------------------------------------------------------------------
    logic st1_valid_reg;
    logic st2_valid_reg;
    logic out_valid_reg;
    logic en_out;
    logic en2;
    logic en1;

    assign en_out   = !out_valid_reg || m_tready;
    assign en2      = !st2_valid_reg || en_out;
    assign en1      = !st1_valid_reg || en2;
    assign s_tready = en1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            st1_valid_reg <= 1'b0;
            st2_valid_reg <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            if (en1) begin
                st1_valid_reg <= s_tvalid;
            end
            if (en2) begin
                st2_valid_reg <= st1_valid_reg;
            end
            if (en_out) begin
                out_valid_reg <= st2_valid_reg;
            end
        end
    end

    // ------------------------------------------------------------------
    // stage 1: linear product, magnitude and table index
    // ------------------------------------------------------------------
    logic signed [W-1:0]  x;
    logic [W:0]           mag_w;
    logic [MW-1:0]        mag_m;
    logic [QW-1:0]        idx_prod;
    logic                 big1_next;
    logic [IW-1:0]        idx1_next;
    logic signed [PW-1:0] prod1_next;

    logic signed [PW-1:0] prod1_reg;
    logic [IW-1:0]        idx1_reg;
    nau_pkg::sig_ctl_t    ctl1_reg;
    nau_pkg::mode_t       mode1_reg;

    always_comb begin
        x          = s_tdata[W-1:0];
        // most negative sample gives 2^(W-1), held by the extra bit
        mag_w      = x[W-1] ? ((W+1)'(0) - {x[W-1], x}) : {1'b0, x};
        mag_m      = MW'(mag_w);
        big1_next  = (mag_m >= EIGHT_M);
        idx_prod   = QW'(mag_m) * DEPTH_Q;
        // out-of-range index only when big, where the table is not used
        idx1_next  = big1_next ? '0 : IW'(idx_prod >> (F + 3));
        prod1_next = PW'(slope_reg) * PW'(x);
    end

    always_ff @(posedge aclk) begin
        if (en1) begin
            prod1_reg     <= prod1_next;
            idx1_reg      <= idx1_next;
            ctl1_reg.big  <= big1_next;
            ctl1_reg.neg  <= x[W-1];
            mode1_reg     <= mode_reg;
        end
    end

    // ------------------------------------------------------------------
    // stage 2: sigmoid table read, linear shift / offset / clamp, step
    // ------------------------------------------------------------------
    logic signed [LW-1:0] lin_full;
    logic [W-1:0]         lin2_next;
    logic                 clip2_next;
    logic [W-1:0]         step2_next;

    logic [W-1:0]         lin2_reg;
    logic                 clip2_reg;
    logic [W-1:0]         step2_reg;
    nau_pkg::mode_t       mode2_reg;
    logic [SW-1:0]        sig2;

    nau_sig_rom #(
        .FRAC_BITS       (F),
        .SIG_TABLE_DEPTH (D)
    ) u_sig_rom (
        .aclk (aclk),
        .en   (en2),
        .idx  (idx1_reg),
        .ctl  (ctl1_reg),
        .sig  (sig2)
    );

    always_comb begin
        // arithmetic shift is the floor of the scaled product
        lin_full = (LW'(prod1_reg) >>> F) + LW'(offset_reg);
        priority if (lin_full > LMAX) begin
            lin2_next  = W'(LMAX);
            clip2_next = 1'b1;
        end else if (lin_full < LMIN) begin
            lin2_next  = W'(LMIN);
            clip2_next = 1'b1;
        end else begin
            lin2_next  = W'(lin_full);
            clip2_next = 1'b0;
        end
        step2_next = ctl1_reg.neg ? '0 : sat_u(ONE_X);
    end

    always_ff @(posedge aclk) begin
        if (en2) begin
            lin2_reg  <= lin2_next;
            clip2_reg <= clip2_next;
            step2_reg <= step2_next;
            mode2_reg <= mode1_reg;
        end
    end

    // ------------------------------------------------------------------
    // output stage: derivative product and function select
    // ------------------------------------------------------------------
    logic [SW-1:0]   one_minus;
    logic [2*SW-1:0] deriv_prod;
    logic [W-1:0]    act_next;
    logic            clip_next;
    logic [W-1:0]    act_reg;
    logic            clip_reg;

    always_comb begin
        one_minus  = ONE_S - sig2;
        deriv_prod = (2*SW)'(sig2) * (2*SW)'(one_minus);
        clip_next  = 1'b0;
        unique case (mode2_reg)
            nau_pkg::MODE_STEP: begin
                act_next = step2_reg;
            end
            nau_pkg::MODE_LINEAR: begin
                act_next  = lin2_reg;
                clip_next = clip2_reg;
            end
            nau_pkg::MODE_SIGMOID: begin
                act_next = sat_u(XW'(sig2));
            end
            nau_pkg::MODE_DERIV: begin
                act_next = sat_u(XW'(deriv_prod >> F));
            end
            default: begin
                act_next = '0;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (en_out) begin
            act_reg  <= act_next;
            clip_reg <= clip_next;
        end
    end

    assign m_tvalid   = out_valid_reg;
    assign m_tdata    = TW'(act_reg);
    assign m_tuser[0] = clip_reg;

    // ------------------------------------------------------------------
    // assertions
    // ------------------------------------------------------------------
    `ASSERT_IMPLIES(a_clip_linear_only, aclk, aresetn,
        m_tvalid && m_tuser[0], mode_reg == nau_pkg::MODE_LINEAR,
        "clipped flag raised outside linear mode")
    `ASSERT_IMPLIES(a_sigmoid_nonneg, aclk, aresetn,
        m_tvalid && (mode_reg == nau_pkg::MODE_SIGMOID || mode_reg == nau_pkg::MODE_DERIV),
        !act_reg[W-1], "sigmoid or derivative result is negative")
    `ASSERT_NEVER(a_ready_when_empty, aclk, aresetn,
        !st1_valid_reg && !s_tready, "input stalled while first stage is empty")

endmodule

`default_nettype wire

[design/nau_sig_rom.sv]
// sigmoid lookup stage: constant table read, saturation to 1.0 and sign fold
`default_nettype none

module nau_sig_rom #(
    parameter int FRAC_BITS       = nau_pkg::FRAC_BITS,
    parameter int SIG_TABLE_DEPTH = nau_pkg::SIG_TABLE_DEPTH
) (
    input  wire logic                               aclk,
    input  wire logic                               en,
    input  wire logic [$clog2(SIG_TABLE_DEPTH)-1:0] idx,
    input  wire nau_pkg::sig_ctl_t                  ctl,
    output logic [FRAC_BITS:0]                      sig
);

    localparam int SW = FRAC_BITS + 1;
    localparam logic [SW-1:0] ONE = SW'(1) << FRAC_BITS;

    logic [SW-1:0] rom_tbl [SIG_TABLE_DEPTH];
    logic [SW-1:0] mag_val;
    logic [SW-1:0] sig_next;
    logic [SW-1:0] sig_reg;

    for (genvar g = 0; g < SIG_TABLE_DEPTH; g++) begin : g_tbl
        localparam logic [SW-1:0] ENTRY = SW'(nau_pkg::sig_rom_entry(
            64'(g), 64'(SIG_TABLE_DEPTH), 64'(FRAC_BITS)));
        assign rom_tbl[g] = ENTRY;
    end

    always_comb begin
        mag_val  = ctl.big ? ONE : rom_tbl[idx];
        sig_next = ctl.neg ? (ONE - mag_val) : mag_val;
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            sig_reg <= sig_next;
        end
    end

    assign sig = sig_reg;

endmodule

`default_nettype wire

[sim/neural_activation_unit_test.sv]
// self-checking stream testbench for the neural activation unit: all four modes, random traffic
module neural_activation_unit_test;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int DW        = nau_pkg::DATA_WIDTH;
    localparam int FB        = nau_pkg::FRAC_BITS;
    localparam int LUT_DEPTH = nau_pkg::SIG_TABLE_DEPTH;
    localparam int TDATA_W   = ((DW + 7) / 8) * 8;
    localparam int ONE_Q     = 1 << FB;
    localparam int ACT_MAX   = (1 << (DW - 1)) - 1;
    localparam int ACT_MIN   = -(1 << (DW - 1));

    // index past the last register, writes there must be dropped
    localparam logic [1:0] REG_UNUSED = 2'd3;

    localparam int RESET_CYCLES  = 12;
    localparam int LONG_HOLD     = 150;  // receiver stall that backs up the pipe
    localparam int DRAIN_CYCLES  = 8;    // pipe depth is 3, allow some slack
    localparam int STALL_LIMIT   = 1000; // cycles with no transfer of any kind
    localparam int RAND_PHASES   = 10;
    localparam int PHASE_ITEMS   = 87;
    localparam int HOLD_ITEMS    = 60;
    localparam int REPORT_LIMIT  = 40;

    // receiver ready patterns
    typedef enum logic [1:0] {
        RX_OPEN,    // always ready
        RX_COIN,    // ready half the time
        RX_MOSTLY,  // rare stalls
        RX_SPARSE   // mostly stalled
    } rx_style_t;

    typedef struct packed {
        logic signed [DW-1:0] activation;
        logic                 clipped;
    } act_result_t;

    // ---------------------------------------------------------------
    // clock, reset and dut ports, every input known from time zero
    // ---------------------------------------------------------------
    logic               aclk     = 1'b0;
    logic               aresetn  = 1'b0;
    logic               s_tvalid = 1'b0;
    logic               s_tready;
    logic [TDATA_W-1:0] s_tdata  = '0;  // sample
    logic               m_tvalid;
    logic               m_tready = 1'b0;
    logic [TDATA_W-1:0] m_tdata;        // activation
    logic [0:0]         m_tuser;        // clipped
    logic               psel     = 1'b0;
    logic               penable  = 1'b0;
    logic               pwrite   = 1'b0;
    logic [nau_pkg::ADDR_WIDTH-1:0] paddr = '0;
    logic [31:0]        pwdata   = '0;
    logic [31:0]        prdata;
    logic               pready;

    always begin
        #1 aclk = 1'b1;
        #1 aclk = 1'b0;
    end

    neural_activation_unit dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    // ---------------------------------------------------------------
    // activation predictor: shadow registers and sigmoid table
    // ---------------------------------------------------------------
    nau_pkg::mode_t       cfg_mode   = nau_pkg::MODE_SIGMOID;
    logic signed [DW-1:0] cfg_slope  = DW'(ONE_Q);
    logic signed [DW-1:0] cfg_offset = '0;
    int                   sig_lut [LUT_DEPTH];

    // table entry i = round(2^FB / (1 + exp(-(2i+1)*4/depth))), exact integer math:
    // taylor series for exp(-a/16) in q30, squared four times
    initial begin : fill_sig_lut
        longint unsigned arg;
        longint unsigned term;
        longint unsigned ex;
        longint unsigned den;
        longint          acc;
        for (int i = 0; i < LUT_DEPTH; i++) begin
            arg  = ((64'(2 * i + 1) << 30) + 64'(2 * LUT_DEPTH))
                   / 64'(4 * LUT_DEPTH);
            term = nau_pkg::Q30;
            acc  = longint'(nau_pkg::Q30);
            for (int k = 1; k <= 16; k++) begin
                term = ((term * arg) >> 30) / 64'(k);
                if (k % 2 == 1) begin
                    acc = acc - longint'(term);
                end else begin
                    acc = acc + longint'(term);
                end
            end
            ex = unsigned'(acc);
            for (int k = 0; k < 4; k++) begin
                ex = (ex * ex + (nau_pkg::Q30 >> 1)) >> 30;
            end
            den = nau_pkg::Q30 + ex;
            sig_lut[i] = int'(((64'd1 << (FB + 31)) + den) / (64'd2 * den));
        end
    end

    // sigmoid level of x, 0 .. 1.0; at or beyond +-8.0 the table is bypassed
    function automatic int sigmoid_level(input logic signed [DW-1:0] x);
        int xi;
        int mag;
        int s;
        xi  = int'(x);
        mag = (xi < 0) ? -xi : xi;
        if (mag >= (8 << FB)) begin
            s = ONE_Q;
        end else begin
            s = sig_lut[(mag * LUT_DEPTH) >> (FB + 3)];
        end
        return (xi < 0) ? ONE_Q - s : s;
    endfunction

    function automatic act_result_t compute_activation(input logic signed [DW-1:0] x);
        act_result_t r;
        longint      prod;
        longint      lin;
        int          s;
        r.clipped = 1'b0;
        case (cfg_mode)
            nau_pkg::MODE_STEP: begin
                r.activation = (x < 0) ? '0 : DW'(ONE_Q);
            end
            nau_pkg::MODE_LINEAR: begin
                // arithmetic shift floors toward minus infinity
                prod = longint'(cfg_slope) * longint'(x);
                lin  = (prod >>> FB) + longint'(cfg_offset);
                if (lin > ACT_MAX) begin
                    lin       = ACT_MAX;
                    r.clipped = 1'b1;
                end else if (lin < ACT_MIN) begin
                    lin       = ACT_MIN;
                    r.clipped = 1'b1;
                end
                r.activation = DW'(lin);
            end
            nau_pkg::MODE_SIGMOID: begin
                r.activation = DW'(sigmoid_level(x));
            end
            default: begin
                s            = sigmoid_level(x);
                r.activation = DW'((s * (ONE_Q - s)) >> FB);
            end
        endcase
        return r;
    endfunction

    // register write as the block sees it; unknown indexes are dropped
    function automatic void shadow_reg_write(input logic [1:0] idx, input logic [31:0] val);
        case (idx)
            nau_pkg::REG_MODE:   cfg_mode   = nau_pkg::mode_t'(val[1:0]);
            nau_pkg::REG_SLOPE:  cfg_slope  = val[DW-1:0];
            nau_pkg::REG_OFFSET: cfg_offset = val[DW-1:0];
            default: ;
        endcase
    endfunction

    // ---------------------------------------------------------------
    // shared state between stimulus, driver, receiver and checker
    // ---------------------------------------------------------------
    logic [DW-1:0] sample_q[$];        // samples not yet offered
    act_result_t   act_expect_q[$];    // predicted results in order
    logic          s_taken   = 1'b0;   // s request accepted at the last rising edge
    logic          no_gaps   = 1'b0;   // sender offers back to back
    int            hold_req  = 0;      // bumped by stimulus to ask for a long stall
    int            err_count = 0;

    // ---------------------------------------------------------------
    // driver: bursts of random length separated by random gaps
    // ---------------------------------------------------------------
    int burst_left = 0;
    int gap_left   = 0;

    always @(negedge aclk) begin
        if (!aresetn) begin
            s_tvalid <= 1'b0;
        end else if (!s_tvalid || s_taken) begin
            if (gap_left != 0 && !no_gaps) begin
                gap_left <= gap_left - 1;
                s_tvalid <= 1'b0;
            end else if (sample_q.size() != 0) begin
                s_tvalid <= 1'b1;
                s_tdata  <= TDATA_W'(sample_q.pop_front());
                if (burst_left == 0) begin
                    // new burst; one in four has no gap after it
                    burst_left <= $urandom_range(0, 24);
                    gap_left   <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
                end else begin
                    burst_left <= burst_left - 1;
                end
            end else begin
                s_tvalid <= 1'b0;
            end
        end
    end

    // ---------------------------------------------------------------
    // receiver: its own stall pattern, plus a long hold on request
    // ---------------------------------------------------------------
    rx_style_t rx_style   = RX_OPEN;
    int        style_left = 0;
    int        hold_left  = 0;
    int        hold_ack   = 0;

    always @(negedge aclk) begin
        if (hold_left != 0) begin
            hold_left <= hold_left - 1;
            m_tready  <= 1'b0;
        end else if (hold_ack != hold_req) begin
            hold_ack  <= hold_ack + 1;
            hold_left <= LONG_HOLD - 1;
            m_tready  <= 1'b0;
        end else begin
            if (style_left == 0) begin
                rx_style   <= rx_style_t'($urandom_range(0, 3));
                style_left <= $urandom_range(8, 64);
            end else begin
                style_left <= style_left - 1;
            end
            case (rx_style)
                RX_OPEN:   m_tready <= 1'b1;
                RX_COIN:   m_tready <= 1'($urandom_range(0, 1));
                RX_MOSTLY: m_tready <= ($urandom_range(0, 7) != 0);
                default:   m_tready <= ($urandom_range(0, 3) == 0);
            endcase
        end
    end

    // ---------------------------------------------------------------
    // checker and watchdog, sampled at the rising edge
    // ---------------------------------------------------------------
    int quiet_cycles = 0;

    always @(posedge aclk) begin : check_results
        act_result_t want;
        act_result_t got;
        logic        s_fire;
        logic        m_fire;
        logic        p_fire;
        s_fire = aresetn && s_tvalid && s_tready;
        m_fire = aresetn && m_tvalid && m_tready;
        p_fire = psel && penable && pwrite && pready;
        s_taken <= s_fire;

        // prediction uses the registers as they stand, they only change when idle
        if (s_fire) begin
            act_expect_q.push_back(compute_activation(s_tdata[DW-1:0]));
        end

        if (m_fire) begin
            got.activation = m_tdata[DW-1:0];
            got.clipped    = m_tuser[0];
            if (act_expect_q.size() == 0) begin
                err_count++;
                if (err_count <= REPORT_LIMIT) begin
                    $display("%t: result with no request pending: activation %0d clipped %0d",
                             $realtime, got.activation, got.clipped);
                end
            end else begin
                want = act_expect_q.pop_front();
                if (got.activation !== want.activation) begin
                    err_count++;
                    if (err_count <= REPORT_LIMIT) begin
                        $display("%t: activation mismatch: expected %0d got %0d",
                                 $realtime, want.activation, got.activation);
                    end
                end
                if (got.clipped !== want.clipped) begin
                    err_count++;
                    if (err_count <= REPORT_LIMIT) begin
                        $display("%t: clipped mismatch: expected %0d got %0d",
                                 $realtime, want.clipped, got.clipped);
                    end
                end
            end
        end

        // a hung handshake ends the run
        if (s_fire || m_fire || p_fire) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= STALL_LIMIT) begin
            $display("neural_activation_unit_test: done, errors");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    // ---------------------------------------------------------------
    // register writes: setup cycle, then access cycle
    // ---------------------------------------------------------------
    task automatic write_reg(input logic [1:0] idx, input logic [31:0] val);
        @(negedge aclk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= val;
        @(negedge aclk);
        penable <= 1'b1;
        do begin
            @(posedge aclk);
        end while (!pready);
        shadow_reg_write(idx, val);
        @(negedge aclk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    // all three registers; unused upper bits of the write data sometimes carry noise
    task automatic set_regs(input nau_pkg::mode_t m, input logic [DW-1:0] slope,
                            input logic [DW-1:0] offset);
        logic [31:0] noise;
        noise = $urandom;
        write_reg(nau_pkg::REG_MODE, {($urandom_range(0, 1) != 0) ? noise[31:2] : 30'd0, m});
        noise = $urandom;
        write_reg(nau_pkg::REG_SLOPE, {($urandom_range(0, 1) != 0) ? noise[31:16]
                                                                   : {16{slope[DW-1]}}, slope});
        noise = $urandom;
        write_reg(nau_pkg::REG_OFFSET, {($urandom_range(0, 1) != 0) ? noise[31:16]
                                                                    : {16{offset[DW-1]}}, offset});
    endtask

    // every request offered and every result back
    task automatic wait_drained();
        while (sample_q.size() != 0 || s_tvalid || act_expect_q.size() != 0) begin
            @(posedge aclk);
        end
    endtask

    // gain or intercept: unity, zero, extremes, small or anything
    function automatic logic [DW-1:0] pick_coef();
        case ($urandom_range(0, 5))
            0:       return DW'(ONE_Q);
            1:       return DW'($urandom);
            2:       return DW'($urandom_range(0, 2047) - 1024);
            3:       return 16'h7fff;
            4:       return 16'h8000;
            default: return '0;
        endcase
    endfunction

    // samples weighted toward the table range and its edges
    function automatic logic [DW-1:0] pick_sample();
        case ($urandom_range(0, 9))
            0, 1, 2, 3: return DW'($urandom);
            4, 5, 6:    return DW'($urandom_range(0, 4199) - 2100);
            7:          return DW'($urandom_range(0, 15) + (($urandom_range(0, 1) != 0)
                                   ? 2040 : -2056));
            8: begin
                case ($urandom_range(0, 4))
                    0:       return 16'h7fff;
                    1:       return 16'h8000;
                    2:       return 16'h0000;
                    3:       return 16'hffff;
                    default: return 16'h0001;
                endcase
            end
            default:    return DW'($urandom_range(0, 599) - 300);
        endcase
    endfunction

    // ---------------------------------------------------------------
    // stimulus
    // ---------------------------------------------------------------
    initial begin
        nau_pkg::mode_t m;
        repeat (RESET_CYCLES) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        // reset values: sigmoid, unity gain; zero, table edges, +-8.0, most negative
        sample_q = '{16'h0000, 16'h7fff, 16'h8000, 16'h07ff, 16'h0800,
                     16'hf801, 16'hf800, 16'h0008, 16'hfff8};
        wait_drained();

        // unit step, with a write to the unused index that must change nothing
        write_reg(REG_UNUSED, $urandom);
        set_regs(nau_pkg::MODE_STEP, DW'(ONE_Q), '0);
        sample_q = '{16'h0000, 16'hffff, 16'h0001, 16'h7fff, 16'h8000};
        wait_drained();

        // linear at the largest gain and intercept: saturates high and low
        set_regs(nau_pkg::MODE_LINEAR, 16'h7fff, 16'h7fff);
        sample_q = '{16'h7fff, 16'h8000, 16'h0000, 16'hffff};
        wait_drained();

        // linear at the most negative gain and intercept
        set_regs(nau_pkg::MODE_LINEAR, 16'h8000, 16'h8000);
        sample_q = '{16'h7fff, 16'h8000, 16'h0001};
        wait_drained();

        // derivative: peak at zero, tails at +-8.0, small values either side
        set_regs(nau_pkg::MODE_DERIV, 16'h0100, 16'h0000);
        sample_q = '{16'h0000, 16'h0800, 16'hf800, 16'h0064, 16'hff9c};
        wait_drained();

        // random phases, the first four walk through every mode
        for (int p = 0; p < RAND_PHASES; p++) begin
            m = (p < 4) ? nau_pkg::mode_t'(p) : nau_pkg::mode_t'($urandom_range(0, 3));
            set_regs(m, pick_coef(), pick_coef());
            // one phase with no sender gaps at all
            no_gaps = (p == 5);
            for (int i = 0; i < PHASE_ITEMS; i++) begin
                sample_q.push_back(pick_sample());
            end
            wait_drained();

            // long receiver hold while the sender keeps pushing, fills the pipe
            if (p == 6) begin
                set_regs(nau_pkg::mode_t'($urandom_range(0, 3)), pick_coef(), pick_coef());
                no_gaps = 1'b1;
                hold_req++;
                for (int i = 0; i < HOLD_ITEMS; i++) begin
                    sample_q.push_back(pick_sample());
                end
                wait_drained();
            end
            no_gaps = 1'b0;
        end

        // let anything stray come out of the pipe before the verdict
        repeat (DRAIN_CYCLES) @(posedge aclk);
        if (err_count == 0 && act_expect_q.size() == 0) begin
            $display("neural_activation_unit_test: done, clean");
        end else begin
            $display("neural_activation_unit_test: done, errors");
        end
        $finish;
    end

endmodule
